@@ hw/rtl/ramn_pkg.sv @@
// ----------------------------------------------------------------------------
// ramn_pkg
// shared types, constants and the microcode table of the mutex node
// ----------------------------------------------------------------------------
package ramn_pkg;

  localparam int MAX_NODES = 32;
  // deferral mask and node walk never go beyond 32 nodes
  localparam int MASK_W    = (MAX_NODES < 32) ? MAX_NODES : 32;
  localparam int MIDX_W    = $clog2(MASK_W);
  localparam int NODE_W    = 6;
  localparam int SEQ_W     = 16;
  localparam int AWAIT_W   = 5;
  localparam int MAX_RES   = 31;
  localparam int RES_W     = $clog2(MAX_RES);
  localparam int TDATA_W   = 24;
  localparam int TUSER_W   = 2;
  localparam int CFG_A_W   = 1;
  localparam int STEP_W    = 4;

  typedef logic [STEP_W-1:0] step_t;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_OWN_NODE   = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_NODE_COUNT = 1'd1;

  typedef enum logic [1:0] {
    ACT_PEER_REQ   = 2'd0,
    ACT_PEER_REPLY = 2'd1,
    ACT_WISH       = 2'd2,
    ACT_RELEASE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_REPLY   = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_GRANT   = 2'd2
  } kind_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_PREQ,
    OP_EMIT_REPLY,
    OP_REPLY,
    OP_GRANT,
    OP_WISH,
    OP_REQ_STEP,
    OP_REL_LOAD,
    OP_REL_STEP
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_PREQ_SKIP,
    C_NO_GRANT,
    C_WISH_SKIP,
    C_IDX_MORE,
    C_AW_NZ,
    C_WORK_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ramn_cw_t;

  typedef struct packed {
    logic    hold;
    logic    take;
    logic    cond_met;
    action_t action;
  } ramn_stat_t;

  // program steps
  localparam step_t S_FETCH     = 4'd0;
  localparam step_t S_PREQ      = 4'd1;
  localparam step_t S_PREPLY    = 4'd2;
  localparam step_t S_REPLY     = 4'd3;
  localparam step_t S_GRANT_A   = 4'd4;
  localparam step_t S_WISH      = 4'd5;
  localparam step_t S_REQ_LOOP  = 4'd6;
  localparam step_t S_WISH_END  = 4'd7;
  localparam step_t S_GRANT_B   = 4'd8;
  localparam step_t S_REL       = 4'd9;
  localparam step_t S_REL_LOOP  = 4'd10;
  localparam step_t S_REL_END   = 4'd11;

  function automatic ramn_cw_t ucode(input step_t s);
    ramn_cw_t w;
    unique case (s)
      S_FETCH:    w = '{OP_FETCH,      C_DISPATCH,  S_FETCH};
      S_PREQ:     w = '{OP_PREQ,       C_PREQ_SKIP, S_FETCH};
      S_PREPLY:   w = '{OP_EMIT_REPLY, C_ALWAYS,    S_FETCH};
      S_REPLY:    w = '{OP_REPLY,      C_NO_GRANT,  S_FETCH};
      S_GRANT_A:  w = '{OP_GRANT,      C_ALWAYS,    S_FETCH};
      S_WISH:     w = '{OP_WISH,       C_WISH_SKIP, S_FETCH};
      S_REQ_LOOP: w = '{OP_REQ_STEP,   C_IDX_MORE,  S_REQ_LOOP};
      S_WISH_END: w = '{OP_NOP,        C_AW_NZ,     S_FETCH};
      S_GRANT_B:  w = '{OP_GRANT,      C_ALWAYS,    S_FETCH};
      S_REL:      w = '{OP_REL_LOAD,   C_NEVER,     S_FETCH};
      S_REL_LOOP: w = '{OP_REL_STEP,   C_WORK_MORE, S_REL_LOOP};
      S_REL_END:  w = '{OP_NOP,        C_ALWAYS,    S_FETCH};
      default:    w = '{OP_NOP,        C_ALWAYS,    S_FETCH};
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(input action_t a);
    step_t s;
    unique case (a)
      ACT_PEER_REQ:   s = S_PREQ;
      ACT_PEER_REPLY: s = S_REPLY;
      ACT_WISH:       s = S_WISH;
      ACT_RELEASE:    s = S_REL;
      default:        s = S_FETCH;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/ramn_seq.sv @@
// ----------------------------------------------------------------------------
// ramn_seq
// step counter and microcode rom with conditional jumps
// ----------------------------------------------------------------------------
module ramn_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  ramn_pkg::ramn_stat_t  stat,
  output ramn_pkg::ramn_cw_t    cw
);

  ramn_pkg::step_t upc;
  ramn_pkg::step_t upc_next;

  assign cw = ramn_pkg::ucode(upc);

  always_comb begin
    priority if (stat.hold) begin
      upc_next = upc;
    end else if (cw.cond == ramn_pkg::C_DISPATCH) begin
      upc_next = stat.take ? ramn_pkg::dispatch(stat.action) : upc;
    end else if (stat.cond_met) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + ramn_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ramn_pkg::S_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

@@ hw/rtl/ramn_dp.sv @@
// ----------------------------------------------------------------------------
// ramn_dp
// node state, peer walk counters and output register
// ----------------------------------------------------------------------------
module ramn_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ramn_pkg::ramn_cw_t                cw,
  output ramn_pkg::ramn_stat_t              stat,
  input  logic [ramn_pkg::NODE_W-1:0]       own_node,
  input  logic [ramn_pkg::NODE_W-1:0]       node_count,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ramn_pkg::TDATA_W-1:0]      s_tdata,
  input  logic [ramn_pkg::TUSER_W-1:0]      s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ramn_pkg::TDATA_W-1:0]      m_tdata,
  output logic [ramn_pkg::TUSER_W-1:0]      m_tuser,
  output logic                              m_tlast
);

  localparam int NW = ramn_pkg::NODE_W;
  localparam int SW = ramn_pkg::SEQ_W;
  localparam int MW = ramn_pkg::MASK_W;

  // latched request
  logic [NW-1:0]         peer;
  logic [SW-1:0]         pseq;

  // node state
  logic [SW-1:0]                  own_seq;
  logic [SW-1:0]                  highest_seq;
  logic [ramn_pkg::AWAIT_W-1:0]   awaiting;
  logic                           requesting;
  logic [MW-1:0]                  deferred_mask;

  // walk counters
  logic [MW-1:0]                  work;
  logic [NW-1:0]                  idx;
  logic [ramn_pkg::RES_W-1:0]     k;

  // output register payload
  ramn_pkg::kind_t       out_kind;
  logic [NW-1:0]         out_dest;
  logic [SW-1:0]         out_seq;
  logic                  out_last;

  logic [NW-1:0]         n;
  logic                  peer_ok;
  logic                  peer_defer;
  logic                  own_bad;
  logic                  emit_want;
  logic                  emit_go;
  logic                  out_free;
  ramn_pkg::kind_t       e_kind;
  logic [NW-1:0]         e_dest;
  logic                  e_last;
  logic                  cond_met;
  logic                  k_full;

  assign n = (node_count > NW'(MW)) ? NW'(MW) : node_count;
  assign peer_ok  = (peer != '0) && (peer <= n) && (peer != own_node);
  assign peer_defer = requesting &&
                      ((pseq > own_seq) || ((pseq == own_seq) && (peer > own_node)));
  assign own_bad  = (own_node == '0) || (own_node > n);
  assign k_full   = (k == ramn_pkg::RES_W'(ramn_pkg::MAX_RES - 1));

  always_comb begin
    emit_want = 1'b0;
    e_kind    = ramn_pkg::KIND_REPLY;
    e_dest    = peer;
    e_last    = 1'b1;
    unique case (cw.op)
      ramn_pkg::OP_EMIT_REPLY: begin
        emit_want = 1'b1;
      end
      ramn_pkg::OP_GRANT: begin
        emit_want = 1'b1;
        e_kind    = ramn_pkg::KIND_GRANT;
        e_dest    = '0;
      end
      ramn_pkg::OP_REQ_STEP: begin
        emit_want = (idx != own_node);
        e_kind    = ramn_pkg::KIND_REQUEST;
        e_dest    = idx;
        // final peer, or the one before own id when own id closes the walk
        e_last    = (idx == n) ||
                    (((NW+1)'(idx) + (NW+1)'(1) == (NW+1)'(n)) && (own_node == n));
      end
      ramn_pkg::OP_REL_STEP: begin
        emit_want = work[0];
        e_dest    = idx;
        e_last    = (work[MW-1:1] == '0) || k_full;
      end
      default: begin
        emit_want = 1'b0;
      end
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign emit_go  = emit_want && out_free;

  always_comb begin
    unique case (cw.cond)
      ramn_pkg::C_ALWAYS:    cond_met = 1'b1;
      ramn_pkg::C_PREQ_SKIP: cond_met = !peer_ok || peer_defer;
      ramn_pkg::C_NO_GRANT:  cond_met = !(peer_ok && requesting &&
                                          (awaiting == ramn_pkg::AWAIT_W'(1)));
      ramn_pkg::C_WISH_SKIP: cond_met = requesting || own_bad;
      ramn_pkg::C_IDX_MORE:  cond_met = (idx != n);
      ramn_pkg::C_AW_NZ:     cond_met = (awaiting != '0);
      ramn_pkg::C_WORK_MORE: cond_met = (work[MW-1:1] != '0) && !(work[0] && k_full);
      default:               cond_met = 1'b0;
    endcase
  end

  assign s_tready      = (cw.op == ramn_pkg::OP_FETCH);
  assign stat.hold     = emit_want && !out_free;
  assign stat.take     = s_tvalid && s_tready;
  assign stat.cond_met = cond_met;
  assign stat.action   = ramn_pkg::action_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      own_seq       <= '0;
      highest_seq   <= '0;
      awaiting      <= '0;
      requesting    <= 1'b0;
      deferred_mask <= '0;
    end else begin
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (!stat.hold) begin
        unique case (cw.op)
          ramn_pkg::OP_PREQ: begin
            if (peer_ok) begin
              if (pseq > highest_seq) begin
                highest_seq <= pseq;
              end
              if (peer_defer) begin
                deferred_mask <= deferred_mask |
                                 (MW'(1) << ramn_pkg::MIDX_W'(peer - NW'(1)));
              end
            end
          end
          ramn_pkg::OP_REPLY: begin
            if (peer_ok && requesting && (awaiting != '0)) begin
              awaiting <= awaiting - ramn_pkg::AWAIT_W'(1);
            end
          end
          ramn_pkg::OP_WISH: begin
            if (!requesting && !own_bad) begin
              requesting <= 1'b1;
              own_seq    <= (highest_seq == '1) ? '1 : highest_seq + SW'(1);
              awaiting   <= ramn_pkg::AWAIT_W'(n - NW'(1));
            end
          end
          ramn_pkg::OP_REL_LOAD: begin
            requesting    <= 1'b0;
            awaiting      <= '0;
            deferred_mask <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // walk counters, latched request and output payload, no reset needed
  always_ff @(posedge clk) begin
    if (!stat.hold) begin
      unique case (cw.op)
        ramn_pkg::OP_FETCH: begin
          if (s_tvalid) begin
            peer <= s_tdata[NW-1:0];
            pseq <= s_tdata[NW+SW-1:NW];
          end
        end
        ramn_pkg::OP_WISH: begin
          idx <= NW'(1);
        end
        ramn_pkg::OP_REQ_STEP: begin
          idx <= idx + NW'(1);
        end
        ramn_pkg::OP_REL_LOAD: begin
          work <= deferred_mask;
          idx  <= NW'(1);
          k    <= '0;
        end
        ramn_pkg::OP_REL_STEP: begin
          work <= work >> 1;
          idx  <= idx + NW'(1);
          if (work[0]) begin
            k <= k + ramn_pkg::RES_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
    if (emit_go) begin
      out_kind <= e_kind;
      out_dest <= e_dest;
      out_seq  <= own_seq;
      out_last <= e_last;
    end
  end

  assign m_tdata = {(ramn_pkg::TDATA_W - SW - NW)'(0), out_seq, out_dest};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

@@ hw/rtl/ricart_agrawala_mutex_node_unit.sv @@
// ----------------------------------------------------------------------------
// ricart_agrawala_mutex_node_unit
// one node of ricart-agrawala distributed mutual exclusion
// ----------------------------------------------------------------------------
// usage
//   s_* channel carries events: tuser is the action (peer request, peer
//   reply, wish to enter, release), tdata the peer id and peer sequence.
//   m_* channel carries messages: tuser is the kind (reply, request,
//   grant), tdata the destination node and own sequence number, tlast
//   marks the final message caused by one event.
//   cfg_we/cfg_addr/cfg_data write own_node (index 0) or node_count
//   (index 1); write only while the node is idle.
// timing
//   a microcoded sequencer handles one event at a time; s_tready is high
//   only on the fetch step. unless the output stalls, the walk over peers
//   or deferred bits (node_count capped at 32) runs one step per cycle
//   and the single output register takes one message per cycle.
// reset
//   rst clears all node state, sets own_node to 1 and node_count to 2.
// stall
//   when m_tready is low the step that wants to send holds in place and
//   the output register keeps its message unchanged.
// ----------------------------------------------------------------------------
module ricart_agrawala_mutex_node_unit (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [ramn_pkg::CFG_A_W-1:0]      cfg_addr,
  input  logic [ramn_pkg::NODE_W-1:0]       cfg_data,
  // event input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ramn_pkg::TDATA_W-1:0]      s_tdata,   // peer_node[5:0], peer_seq[21:6]
  input  logic [ramn_pkg::TUSER_W-1:0]      s_tuser,   // action[1:0]
  // message output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ramn_pkg::TDATA_W-1:0]      m_tdata,   // dest_node[5:0], seq_out[21:6]
  output logic [ramn_pkg::TUSER_W-1:0]      m_tuser,   // msg_kind[1:0]
  output logic                              m_tlast
);

  // configuration registers
  logic [ramn_pkg::NODE_W-1:0] own_node;
  logic [ramn_pkg::NODE_W-1:0] node_count;

  // sequencer <-> datapath
  ramn_pkg::ramn_cw_t   cw;
  ramn_pkg::ramn_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node   <= ramn_pkg::NODE_W'(1);
      node_count <= ramn_pkg::NODE_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ramn_pkg::REG_OWN_NODE:   own_node   <= cfg_data;
        ramn_pkg::REG_NODE_COUNT: node_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // program counter and control store
  ramn_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw)
  );

  // node state, walk counters, output register
  ramn_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cw         (cw),
    .stat       (stat),
    .own_node   (own_node),
    .node_count (node_count),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

@@ hw/rtl/ramn_chk.sv @@
// ----------------------------------------------------------------------------
// ramn_chk
// port-level checks on the message channel of the mutex node
// ----------------------------------------------------------------------------
module ramn_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ramn_pkg::TDATA_W-1:0]      m_tdata,
  input logic [ramn_pkg::TUSER_W-1:0]      m_tuser,
  input logic                              m_tlast
);

  // stalled message holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled message changed");

  // only defined message kinds
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ramn_pkg::KIND_REPLY) || (m_tuser == ramn_pkg::KIND_REQUEST) ||
                 (m_tuser == ramn_pkg::KIND_GRANT))
    else $error("undefined message kind");

  // grant is local and ends its request
  a_grant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ramn_pkg::KIND_GRANT) |-> (m_tdata[5:0] == '0) && m_tlast)
    else $error("grant with destination or without tlast");

  // peer messages always name a node
  a_dest: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ramn_pkg::KIND_GRANT) |-> (m_tdata[5:0] != '0))
    else $error("peer message to node zero");

endmodule

bind ricart_agrawala_mutex_node_unit ramn_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ tb/ricart_agrawala_mutex_node_unit_test.sv @@
// ----------------------------------------------------------------------------
// ricart_agrawala_mutex_node_unit_test
// self-checking bench for one ricart-agrawala mutual exclusion node
// ----------------------------------------------------------------------------
// a queue of pending events feeds a clocked driver on the s_* channel; every
// accepted event is run through a cycle-free model of the node that appends
// the messages the node must send to a queue of due messages. a clocked
// monitor on the m_* channel checks each message against the oldest due one.
// stimulus: a short directed part (invalid peers, stray replies, repeated
// wish, lone node, misconfigured node, tie break, overfull deferral,
// sequence saturation), then full request rounds with random content and
// noise under several node configurations and idling profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ricart_agrawala_mutex_node_unit_test;
  import ramn_pkg::*;

  typedef struct packed {
    action_t           act;
    logic [NODE_W-1:0] peer;
    logic [SEQ_W-1:0]  seq;
  } node_ev_t;

  typedef struct packed {
    kind_t             kind;
    logic [NODE_W-1:0] dest;
    logic [SEQ_W-1:0]  seq;
    logic              tail;
  } node_msg_t;

  // cycles the node may still be busy after its last message (release walk)
  localparam int SETTLE_CYCLES = 48;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr = '0;
  logic [NODE_W-1:0]   cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata = '0;  // peer_node[5:0], peer_seq[21:6]
  logic [TUSER_W-1:0]  s_tuser = '0;  // action[1:0]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;       // dest_node[5:0], seq_out[21:6]
  logic [TUSER_W-1:0]  m_tuser;       // msg_kind[1:0]
  logic                m_tlast;

  ricart_agrawala_mutex_node_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // node model: configuration and protocol state, reset values
  // --------------------------------------------------------------------------
  logic [NODE_W-1:0]  cfg_own   = 6'd1;
  logic [NODE_W-1:0]  cfg_count = 6'd2;
  logic [SEQ_W-1:0]   my_seq    = '0;
  logic [SEQ_W-1:0]   top_seq   = '0;
  logic [AWAIT_W-1:0] awaiting  = '0;
  logic               requesting = 1'b0;
  logic [31:0]        owed_mask = '0;   // bit i-1 set: reply owed to node i

  node_ev_t  ev_queue[$];   // events not yet offered to the node
  node_msg_t due_msgs[$];   // messages the node still has to send
  bit        ev_busy = 1'b0;
  int        gap_pct = 0;
  int        stall_pct = 0;
  int        err_cnt = 0;
  logic [SEQ_W-1:0] gen_high = '0;   // stimulus-side copy of the highest sequence

  // node count as the node sees it: capped at 32 and at the build limit
  function automatic int live_nodes();
    int c;
    c = cfg_count;
    if (c > 32) c = 32;
    if (c > MAX_NODES) c = MAX_NODES;
    return c;
  endfunction

  function automatic bit peer_ok(input logic [NODE_W-1:0] p);
    return p >= 1 && p <= live_nodes() && p != cfg_own;
  endfunction

  function automatic node_msg_t make_msg(input kind_t k, input int dest);
    node_msg_t m;
    m.kind = k;
    m.dest = NODE_W'(dest);
    m.seq  = my_seq;
    m.tail = 1'b0;
    return m;
  endfunction

  // one event through the node: updates state, queues the messages it causes
  function automatic void react(input node_ev_t ev);
    node_msg_t batch[$];
    node_msg_t m;
    int n;
    n = live_nodes();
    case (ev.act)
      ACT_PEER_REQ: begin
        if (peer_ok(ev.peer)) begin
          if (ev.seq > top_seq) top_seq = ev.seq;
          // our own pending request wins: lower number, or tie and lower id
          if (requesting && (ev.seq > my_seq || (ev.seq == my_seq && ev.peer > cfg_own)))
            owed_mask[ev.peer - 1] = 1'b1;
          else
            batch.push_back(make_msg(KIND_REPLY, ev.peer));
        end
      end
      ACT_PEER_REPLY: begin
        // stray replies and invalid peers leave no trace
        if (peer_ok(ev.peer) && requesting && awaiting != 0) begin
          awaiting = awaiting - 1'b1;
          if (awaiting == 0) batch.push_back(make_msg(KIND_GRANT, 0));
        end
      end
      ACT_WISH: begin
        if (!requesting && cfg_own >= 1 && cfg_own <= n) begin
          requesting = 1'b1;
          my_seq = (top_seq == 16'hFFFF) ? 16'hFFFF : top_seq + 16'd1;
          awaiting = AWAIT_W'(n - 1);
          for (int i = 1; i <= n; i++)
            if (i != cfg_own && batch.size() < MAX_RES)
              batch.push_back(make_msg(KIND_REQUEST, i));
          // lone node: nobody to ask, granted at once
          if (awaiting == 0) batch.push_back(make_msg(KIND_GRANT, 0));
        end
      end
      ACT_RELEASE: begin
        requesting = 1'b0;
        awaiting = '0;
        // owed replies go out lowest node first, anything past the cap is lost
        for (int i = 0; i < 32; i++)
          if (owed_mask[i] && batch.size() < MAX_RES)
            batch.push_back(make_msg(KIND_REPLY, i + 1));
        owed_mask = '0;
      end
    endcase
    if (batch.size() > 0) begin
      m = batch[batch.size() - 1];
      m.tail = 1'b1;
      batch[batch.size() - 1] = m;
    end
    foreach (batch[i]) due_msgs.push_back(batch[i]);
  endfunction

  // --------------------------------------------------------------------------
  // event driver: one request offered at a time, random gaps
  // --------------------------------------------------------------------------
  node_ev_t cur_ev, nxt_ev;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      ev_busy = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        react(cur_ev);
        ev_busy = 1'b0;
      end
      if (!s_tvalid || s_tready) begin
        if (ev_queue.size() != 0 && (gap_pct == 0 || $urandom_range(1, 100) > gap_pct)) begin
          nxt_ev = ev_queue.pop_front();
          cur_ev = nxt_ev;
          ev_busy = 1'b1;
          s_tvalid <= 1'b1;
          s_tdata  <= TDATA_W'({nxt_ev.seq, nxt_ev.peer});
          s_tuser  <= nxt_ev.act;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // message monitor: compare against the oldest due message, random stalls
  // --------------------------------------------------------------------------
  node_msg_t want, seen;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.kind = kind_t'(m_tuser);
      seen.dest = m_tdata[NODE_W-1:0];
      seen.seq  = m_tdata[NODE_W+SEQ_W-1:NODE_W];
      seen.tail = m_tlast;
      if (due_msgs.size() == 0) begin
        $display({"%0t: message mismatch, expected no message,",
                  " got kind=%0d dest=%0d seq=%0d last=%0b"},
                 $time, seen.kind, seen.dest, seen.seq, seen.tail);
        err_cnt++;
      end else begin
        want = due_msgs.pop_front();
        if (seen.kind !== want.kind || seen.dest !== want.dest ||
            seen.seq !== want.seq || seen.tail !== want.tail) begin
          $display({"%0t: message mismatch, expected kind=%0d dest=%0d seq=%0d last=%0b,",
                    " got kind=%0d dest=%0d seq=%0d last=%0b"},
                   $time, want.kind, want.dest, want.seq, want.tail,
                   seen.kind, seen.dest, seen.seq, seen.tail);
          err_cnt++;
        end
      end
    end
    m_tready <= (stall_pct == 0) || ($urandom_range(1, 100) > stall_pct);
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_ev(input action_t a, input int peer, input int seq);
    node_ev_t e;
    e.act  = a;
    e.peer = NODE_W'(peer);
    e.seq  = SEQ_W'(seq);
    // track the highest sequence so later numbers stay close to the node's own
    if (a == ACT_PEER_REQ && peer_ok(e.peer) && e.seq > gen_high) gen_high = e.seq;
    ev_queue.push_back(e);
  endfunction

  // mostly around our own number so ties and both orders show up
  function automatic int pick_seq(input bit wide);
    int v;
    if (wide && $urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, gen_high);
    v = gen_high + $urandom_range(0, 3);
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic int any_peer();
    int n, p;
    n = live_nodes();
    if (n < 2) return 0;
    do p = $urandom_range(1, n); while (p == cfg_own);
    return p;
  endfunction

  function automatic void add_noise(input bit wide);
    action_t a;
    a = action_t'($urandom_range(0, 3));
    add_ev(a, $urandom_range(0, 63),
           (a == ACT_PEER_REQ) ? pick_seq(wide) : $urandom_range(0, 65535));
  endfunction

  // one request round: wish, replies from all peers in random order with
  // competing requests mixed in, then release; sometimes cut short
  function automatic void play_round(input bit wide, inout int made);
    int peers[$];
    int n, j, tmp, cut;
    n = live_nodes();
    for (int i = 1; i <= n; i++) if (i != cfg_own) peers.push_back(i);
    for (int i = peers.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = peers[i];
      peers[i] = peers[j];
      peers[j] = tmp;
    end
    repeat ($urandom_range(0, 2)) begin
      add_ev(ACT_PEER_REQ, any_peer(), pick_seq(wide));
      made++;
    end
    add_ev(ACT_WISH, $urandom_range(0, 63), $urandom_range(0, 65535));
    made++;
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, peers.size()) : peers.size();
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        add_ev(ACT_PEER_REQ, any_peer(), pick_seq(wide));
        made++;
      end
      if ($urandom_range(0, 9) == 0) add_noise(wide);
      add_ev(ACT_PEER_REPLY, peers[i], $urandom_range(0, 65535));
      made++;
    end
    if ($urandom_range(0, 3) == 0) add_noise(wide);
    add_ev(ACT_RELEASE, $urandom_range(0, 63), $urandom_range(0, 65535));
    made++;
  endfunction

  // wait until every event is taken and every message seen, then let the
  // node finish any walk that produces nothing
  task automatic drain();
    while (ev_queue.size() != 0 || ev_busy || due_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= NODE_W'(val);
    if (idx == REG_OWN_NODE) cfg_own = NODE_W'(val);
    else cfg_count = NODE_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int own, input int cnt);
    write_reg(REG_OWN_NODE, own);
    write_reg(REG_NODE_COUNT, cnt);
  endtask

  task automatic random_phase(input int own, input int cnt, input int gap, input int stall,
                              input bit wide, input int items);
    int made;
    made = 0;
    configure(own, cnt);
    gap_pct = gap;
    stall_pct = stall;
    while (made < items) play_round(wide, made);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: node 1 of 2
    add_ev(ACT_PEER_REQ, 2, 0);            // answered at once
    add_ev(ACT_PEER_REQ, 0, 5);            // invalid peers are dropped
    add_ev(ACT_PEER_REQ, 3, 5);
    add_ev(ACT_PEER_REQ, 1, 5);
    add_ev(ACT_PEER_REPLY, 2, 0);          // stray reply, not requesting
    add_ev(ACT_RELEASE, 0, 0);             // nothing owed
    add_ev(ACT_WISH, 63, 65535);
    add_ev(ACT_WISH, 0, 0);                // repeated wish
    add_ev(ACT_PEER_REQ, 2, 1);            // tie, peer id higher: deferred
    add_ev(ACT_PEER_REPLY, 63, 0);
    add_ev(ACT_PEER_REPLY, 2, 0);          // grant
    add_ev(ACT_PEER_REPLY, 2, 0);          // nothing awaited any more
    add_ev(ACT_RELEASE, 0, 0);             // owed reply goes out
    drain();

    // tie with a lower peer id is answered, a higher number is deferred
    configure(2, 2);
    add_ev(ACT_WISH, 0, 0);
    add_ev(ACT_PEER_REQ, 1, gen_high + 1);
    add_ev(ACT_PEER_REQ, 1, gen_high + 1);
    add_ev(ACT_PEER_REPLY, 1, 0);
    add_ev(ACT_RELEASE, 0, 0);
    drain();

    // lone node
    configure(1, 1);
    add_ev(ACT_WISH, 0, 0);
    add_ev(ACT_PEER_REQ, 2, 3);
    add_ev(ACT_RELEASE, 0, 0);
    drain();

    // misconfigured node: own id outside the node range
    configure(0, 3);
    add_ev(ACT_WISH, 0, 0);
    drain();
    configure(63, 0);
    add_ev(ACT_WISH, 0, 0);
    add_ev(ACT_PEER_REQ, 1, 0);
    drain();

    // overfull deferral: 31 peers deferred, then a new own id lets node 1
    // be deferred as well; release sends 31 replies and drops the last
    gap_pct = 18;
    stall_pct = 18;
    configure(1, 32);
    add_ev(ACT_WISH, 0, 0);
    for (int p = 2; p <= 32; p++) add_ev(ACT_PEER_REQ, p, gen_high + 1 + $urandom_range(0, 40));
    drain();
    configure(2, 32);
    add_ev(ACT_PEER_REQ, 1, gen_high + 5);
    add_ev(ACT_RELEASE, 0, 0);
    drain();

    // random rounds under different configurations and idling
    random_phase(3, 5, 0, 0, 1'b0, 95);
    random_phase(32, 32, 78, 0, 1'b0, 80);
    random_phase(7, 7, 0, 78, 1'b0, 95);
    random_phase(4, 63, 18, 18, 1'b1, 80);

    // sequence numbers saturate at the top
    configure(1, 2);
    gap_pct = 0;
    stall_pct = 0;
    add_ev(ACT_PEER_REQ, 2, 65535);
    add_ev(ACT_WISH, 0, 0);
    add_ev(ACT_PEER_REQ, 2, 65535);
    add_ev(ACT_PEER_REPLY, 2, 0);
    add_ev(ACT_RELEASE, 0, 0);
    add_ev(ACT_PEER_REQ, 2, 65535);
    drain();

    if (err_cnt == 0 && due_msgs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ ricart_agrawala_mutex_node_unit.f @@
hw/rtl/ramn_pkg.sv
hw/rtl/ramn_seq.sv
hw/rtl/ramn_dp.sv
hw/rtl/ricart_agrawala_mutex_node_unit.sv
hw/rtl/ramn_chk.sv
tb/ricart_agrawala_mutex_node_unit_test.sv
